[design/assert_macros.svh]
// assertion macros used by the torus_vertex_generator design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

[design/tvg_pkg.sv]
// types and constants of the torus vertex generator
`timescale 1ns / 1ps
package tvg_pkg;
	localparam int MAX_SEGMENTS_DEF     = 1024;
	localparam int ANGLE_ITERATIONS_DEF = 16;
	localparam int SEG_W  = 11;
	localparam int DIV_W  = 27;
	localparam int QUO_W  = 17;
	localparam int CS_W   = 33;
	localparam int TRIG_W = 32;

	typedef logic signed [CS_W-1:0] cord_t;
	typedef logic signed [TRIG_W-1:0] trig_t;

	localparam cord_t CORDIC_GAIN = 33'sd652032874;
	localparam cord_t Q30_ONE     = 33'sd1073741824;
	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

	localparam cord_t ATAN_Q30 [24] = '{
		33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
		33'sd67021687, 33'sd33543516, 33'sd16775851, 33'sd8388437,
		33'sd4194283, 33'sd2097149, 33'sd1048576, 33'sd524288,
		33'sd262144, 33'sd131072, 33'sd65536, 33'sd32768,
		33'sd16384, 33'sd8192, 33'sd4096, 33'sd2048,
		33'sd1024, 33'sd512, 33'sd256, 33'sd128
	};

	typedef enum logic [1:0] {
		REG_MAIN_RADIUS,
		REG_TUBE_RADIUS,
		REG_MAIN_SEGMENTS,
		REG_TUBE_SEGMENTS
	} cfg_reg_t;

	typedef struct packed {
		cord_t x;
		cord_t y;
		cord_t z;
		logic [1:0] quad;
	} cordic_word_t;
endpackage

[design/tvg_if.sv]
// handshake channels for grid coordinates and vertices
`timescale 1ns / 1ps
interface tvg_in_if;
	logic valid;
	logic ready;
	logic [10:0] ring_index;
	logic [10:0] tube_index;
	modport source(output valid, output ring_index, output tube_index, input ready);
	modport sink(input valid, input ring_index, input tube_index, output ready);
endinterface

interface tvg_out_if;
	logic valid;
	logic ready;
	logic signed [17:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [17:0] pos_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic [16:0] tex_u;
	logic [16:0] tex_v;
	modport source(output valid, output pos_x, output pos_y, output pos_z,
		output normal_x, output normal_y, output normal_z, output tex_u, output tex_v,
		input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z,
		input normal_x, input normal_y, input normal_z, input tex_u, input tex_v,
		output ready);
endinterface

[design/tvg_div_cell.sv]
// one quotient bit of the pipelined restoring divider
`timescale 1ns / 1ps
module tvg_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [tvg_pkg::DIV_W-1:0] rem_i,
	input  logic [tvg_pkg::SEG_W-1:0] seg_i,
	input  logic [tvg_pkg::QUO_W-1:0] quo_i,
	output logic [tvg_pkg::DIV_W-1:0] rem_q,
	output logic [tvg_pkg::SEG_W-1:0] seg_q,
	output logic [tvg_pkg::QUO_W-1:0] quo_q
);
	localparam int DW = tvg_pkg::DIV_W;
	localparam int QW = tvg_pkg::QUO_W;

	logic [DW-1:0] sub;
	logic take;

	assign sub  = DW'(seg_i) << SHIFT;
	assign take = rem_i >= sub;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? rem_i - sub : rem_i;
			seg_q <= seg_i;
			quo_q <= quo_i | (QW'(take) << SHIFT);
		end
	end
endmodule

[design/tvg_cordic_cell.sv]
// one rotation step of the pipelined cordic
`timescale 1ns / 1ps
module tvg_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic en,
	input  tvg_pkg::cordic_word_t w_i,
	output tvg_pkg::cordic_word_t w_q
);
	tvg_pkg::cord_t xs;
	tvg_pkg::cord_t ys;
	tvg_pkg::cord_t ang;

	assign xs  = w_i.x >>> IDX;
	assign ys  = w_i.y >>> IDX;
	assign ang = tvg_pkg::ATAN_Q30[IDX];

	always_ff @(posedge clk) begin
		if (en) begin
			w_q.quad <= w_i.quad;
			if (!w_i.z[tvg_pkg::CS_W-1]) begin
				w_q.x <= w_i.x - ys;
				w_q.y <= w_i.y + xs;
				w_q.z <= w_i.z - ang;
			end else begin
				w_q.x <= w_i.x + ys;
				w_q.y <= w_i.y - xs;
				w_q.z <= w_i.z + ang;
			end
		end
	end
endmodule

[design/torus_vertex_generator.sv]
// top level of the torus vertex generator
//
//  channel   dir  words                      handshake
//  vtx_in    in   ring_index, tube_index     valid/ready
//  vtx_out   out  position, normal, texture  valid/ready
//  cfg       in   cfg_index, cfg_data        cfg_we, no wait
//
// one word per cycle while no output word is held
// the line runs through 17 divider cells per index and the cordic cells, all advancing together
// arst_n clears the valid line and loads the register defaults
// a held output word stalls the whole line and drops vtx_in.ready
`timescale 1ns / 1ps
`include "assert_macros.svh"
module torus_vertex_generator #(
	parameter int MAX_SEGMENTS     = tvg_pkg::MAX_SEGMENTS_DEF,
	parameter int ANGLE_ITERATIONS = tvg_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tvg_in_if.sink      vtx_in,
	tvg_out_if.source   vtx_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int SW   = tvg_pkg::SEG_W;
	localparam int DW   = tvg_pkg::DIV_W;
	localparam int QW   = tvg_pkg::QUO_W;
	localparam int N    = ANGLE_ITERATIONS;
	localparam int NDIV = tvg_pkg::QUO_W;
	localparam int L    = NDIV + N + 7;

	logic [15:0]   main_radius_q;
	logic [15:0]   tube_radius_q;
	logic [SW-1:0] main_segments_q;
	logic [SW-1:0] tube_segments_q;
	logic [L-1:0]  vld_q;
	logic          en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_radius_q   <= 16'd256;
			tube_radius_q   <= 16'd64;
			main_segments_q <= 11'd32;
			tube_segments_q <= 11'd16;
		end else if (cfg_we) begin
			unique case (tvg_pkg::cfg_reg_t'(cfg_index))
				tvg_pkg::REG_MAIN_RADIUS:   main_radius_q   <= cfg_data;
				tvg_pkg::REG_TUBE_RADIUS:   tube_radius_q   <= cfg_data;
				tvg_pkg::REG_MAIN_SEGMENTS: main_segments_q <= cfg_data[SW-1:0];
				tvg_pkg::REG_TUBE_SEGMENTS: tube_segments_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	assign en           = !vld_q[L-1] || vtx_out.ready;
	assign vtx_in.ready = en;
	assign vtx_out.valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], vtx_in.valid};
		end
	end

	// input stage: effective counts and dividends
	function automatic logic [SW-1:0] eff_seg(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		if (s == '0) r = SW'(1);
		else if (32'(s) > MAX_SEGMENTS) r = SW'(MAX_SEGMENTS);
		else r = s;
		return r;
	endfunction

	logic [SW-1:0] seg_u, seg_v, idx_u, idx_v;

	always_comb begin
		seg_u = eff_seg(main_segments_q);
		seg_v = eff_seg(tube_segments_q);
		idx_u = (vtx_in.ring_index > seg_u) ? seg_u : vtx_in.ring_index;
		idx_v = (vtx_in.tube_index > seg_v) ? seg_v : vtx_in.tube_index;
	end

	logic [DW-1:0] rem_u [NDIV+1];
	logic [DW-1:0] rem_v [NDIV+1];
	logic [SW-1:0] sg_u  [NDIV+1];
	logic [SW-1:0] sg_v  [NDIV+1];
	logic [QW-1:0] quo_u [NDIV+1];
	logic [QW-1:0] quo_v [NDIV+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_u[0] <= {idx_u, 16'd0} + DW'(seg_u >> 1);
			rem_v[0] <= {idx_v, 16'd0} + DW'(seg_v >> 1);
			sg_u[0]  <= seg_u;
			sg_v[0]  <= seg_v;
			quo_u[0] <= '0;
			quo_v[0] <= '0;
		end
	end

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		tvg_div_cell #(.SHIFT(NDIV - 1 - k)) u_div_u (
			.clk(clk), .en(en),
			.rem_i(rem_u[k]), .seg_i(sg_u[k]), .quo_i(quo_u[k]),
			.rem_q(rem_u[k+1]), .seg_q(sg_u[k+1]), .quo_q(quo_u[k+1])
		);
		tvg_div_cell #(.SHIFT(NDIV - 1 - k)) u_div_v (
			.clk(clk), .en(en),
			.rem_i(rem_v[k]), .seg_i(sg_v[k]), .quo_i(quo_v[k]),
			.rem_q(rem_v[k+1]), .seg_q(sg_v[k+1]), .quo_q(quo_v[k+1])
		);
	end

	// angle stage: turns to radians
	logic [46:0] zp_u, zp_v;
	tvg_pkg::cordic_word_t cw_u [N+1];
	tvg_pkg::cordic_word_t cw_v [N+1];
	logic [QW-1:0] tex_u_d [N+5];
	logic [QW-1:0] tex_v_d [N+5];

	assign zp_u = 47'(quo_u[NDIV][13:0]) * 47'(tvg_pkg::TWO_PI_Q30) + 47'd32768;
	assign zp_v = 47'(quo_v[NDIV][13:0]) * 47'(tvg_pkg::TWO_PI_Q30) + 47'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			cw_u[0] <= '{x: tvg_pkg::CORDIC_GAIN, y: '0, z: {2'b00, zp_u[46:16]},
				quad: quo_u[NDIV][15:14]};
			cw_v[0] <= '{x: tvg_pkg::CORDIC_GAIN, y: '0, z: {2'b00, zp_v[46:16]},
				quad: quo_v[NDIV][15:14]};
			tex_u_d[0] <= quo_u[NDIV];
			tex_v_d[0] <= quo_v[NDIV];
			for (int i = 1; i < N + 5; i++) begin
				tex_u_d[i] <= tex_u_d[i-1];
				tex_v_d[i] <= tex_v_d[i-1];
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		tvg_cordic_cell #(.IDX(i)) u_cord_u (.clk(clk), .en(en), .w_i(cw_u[i]), .w_q(cw_u[i+1]));
		tvg_cordic_cell #(.IDX(i)) u_cord_v (.clk(clk), .en(en), .w_i(cw_v[i]), .w_q(cw_v[i+1]));
	end

	// trig stage: clamp and quadrant fold
	function automatic tvg_pkg::cord_t clamp1(input tvg_pkg::cord_t v);
		tvg_pkg::cord_t r;
		if (v > tvg_pkg::Q30_ONE) r = tvg_pkg::Q30_ONE;
		else if (v < -tvg_pkg::Q30_ONE) r = -tvg_pkg::Q30_ONE;
		else r = v;
		return r;
	endfunction

	function automatic logic [2*tvg_pkg::TRIG_W-1:0] fold(input tvg_pkg::cordic_word_t w);
		tvg_pkg::cord_t x, y, c, s;
		x = clamp1(w.x);
		y = clamp1(w.y);
		unique case (w.quad)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		return {c[tvg_pkg::TRIG_W-1:0], s[tvg_pkg::TRIG_W-1:0]};
	endfunction

	tvg_pkg::trig_t ct_s3, st_s3, cp_s3, sp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			{ct_s3, st_s3} <= fold(cw_u[N]);
			{cp_s3, sp_s3} <= fold(cw_v[N]);
		end
	end

	// product stages
	logic signed [47:0] ring_raw_s4, py_raw_s4;
	logic signed [63:0] nx_raw_s4, nz_raw_s4;
	tvg_pkg::trig_t ct_s4, st_s4, sp_s4;
	logic signed [47:0] ring_rnd;
	logic signed [25:0] ring_s5;
	logic signed [47:0] py_raw_s5, py_raw_s6;
	logic signed [63:0] nx_raw_s5, nz_raw_s5, nx_raw_s6, nz_raw_s6;
	tvg_pkg::trig_t ct_s5, st_s5, sp_s5, sp_s6;
	logic signed [57:0] px_raw_s6, pz_raw_s6;

	assign ring_rnd = ring_raw_s4 + 48'sh200000;

	always_ff @(posedge clk) begin
		if (en) begin
			ring_raw_s4 <= $signed({2'b00, main_radius_q, 30'd0})
				+ $signed({1'b0, tube_radius_q}) * cp_s3;
			py_raw_s4   <= $signed({1'b0, tube_radius_q}) * sp_s3;
			nx_raw_s4   <= cp_s3 * ct_s3;
			nz_raw_s4   <= cp_s3 * st_s3;
			ct_s4 <= ct_s3;
			st_s4 <= st_s3;
			sp_s4 <= sp_s3;

			ring_s5   <= ring_rnd[47:22];
			py_raw_s5 <= py_raw_s4;
			nx_raw_s5 <= nx_raw_s4;
			nz_raw_s5 <= nz_raw_s4;
			ct_s5 <= ct_s4;
			st_s5 <= st_s4;
			sp_s5 <= sp_s4;

			px_raw_s6 <= ring_s5 * ct_s5;
			pz_raw_s6 <= ring_s5 * st_s5;
			py_raw_s6 <= py_raw_s5;
			nx_raw_s6 <= nx_raw_s5;
			nz_raw_s6 <= nz_raw_s5;
			sp_s6     <= sp_s5;
		end
	end

	// output stage: round and saturate
	function automatic logic signed [63:0] rnd_sat(input logic signed [63:0] v,
		input int n, input logic signed [63:0] lo, input logic signed [63:0] hi);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< (n - 1))) >>> n;
		if (r < lo) r = lo;
		else if (r > hi) r = hi;
		return r;
	endfunction

	logic signed [63:0] px_w, py_w, pz_w, nx_w, ny_w, nz_w;

	always_comb begin
		px_w = rnd_sat(64'(px_raw_s6), 38, -64'sd131072, 64'sd131071);
		pz_w = rnd_sat(64'(pz_raw_s6), 38, -64'sd131072, 64'sd131071);
		py_w = rnd_sat(64'(py_raw_s6), 30, -64'sd65536, 64'sd65535);
		nx_w = rnd_sat(nx_raw_s6, 46, -64'sd16384, 64'sd16384);
		nz_w = rnd_sat(nz_raw_s6, 46, -64'sd16384, 64'sd16384);
		ny_w = rnd_sat(64'(sp_s6), 16, -64'sd16384, 64'sd16384);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vtx_out.pos_x    <= px_w[17:0];
			vtx_out.pos_y    <= py_w[16:0];
			vtx_out.pos_z    <= pz_w[17:0];
			vtx_out.normal_x <= nx_w[15:0];
			vtx_out.normal_y <= ny_w[15:0];
			vtx_out.normal_z <= nz_w[15:0];
			vtx_out.tex_u    <= tex_u_d[N+4];
			vtx_out.tex_v    <= tex_v_d[N+4];
		end
	end

	`ASSERT_IMPL(a_stall_blocks_in, clk, arst_n, vtx_out.valid && !vtx_out.ready, !vtx_in.ready)
	`ASSERT_NEXT(a_accept_enters, clk, arst_n, vtx_in.valid && vtx_in.ready, vld_q[0])
	`ASSERT_IMPL(a_tex_u_range, clk, arst_n, vtx_out.valid, vtx_out.tex_u <= 17'd65536)
endmodule
